// ----- design/i2crtm_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C register transaction master - shared definitions
// Stage codes, operation codes and configuration register indexes.
// ----------------------------------------------------------------------------
package i2crtm_pkg;

  localparam int unsigned StageW = 4;
  localparam int unsigned StepW  = StageW + 1;
  localparam int unsigned BitW   = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [StageW-1:0] STG_IDLE   = 4'd0;
  localparam logic [StageW-1:0] STG_START  = 4'd1;
  localparam logic [StageW-1:0] STG_ADDRW  = 4'd2;
  localparam logic [StageW-1:0] STG_REG    = 4'd3;
  localparam logic [StageW-1:0] STG_DATA   = 4'd4;
  localparam logic [StageW-1:0] STG_RSTART = 4'd5;
  localparam logic [StageW-1:0] STG_ADDRR  = 4'd6;
  localparam logic [StageW-1:0] STG_READ   = 4'd7;
  localparam logic [StageW-1:0] STG_MACK   = 4'd8;
  localparam logic [StageW-1:0] STG_STOP   = 4'd9;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_DEV_ADDR    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PHASE       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_STOP  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ACK_AFTER   = 3'd4;

  localparam logic [6:0] DEV_ADDR_RST    = 7'd50;
  localparam logic [7:0] PHASE_RST       = 8'd2;
  localparam logic [7:0] START_STOP_RST  = 8'd4;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  localparam logic [BitW-1:0] PART_FIRST = 4'd0;
  localparam logic [BitW-1:0] PART_SETUP = 4'd1;
  localparam logic [BitW-1:0] PART_LAST  = 4'd2;
  localparam logic [BitW-1:0] BITS_BYTE  = 4'd8;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ack_error;
    logic       done_res;
    logic       busy_res;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage

// ----- design/i2c_register_transaction_master.sv -----
// ----------------------------------------------------------------------------
// I2C register transaction master
// Drives single-register write and read transactions on SCL and SDA, one bus
// time unit per tick item.
// ----------------------------------------------------------------------------
// Each item on the slave stream is either a command (write or read of one
// register) or a tick that advances the bus by one time unit and carries the
// sampled SDA level. Every item yields exactly one result with the SCL/SDA
// drive levels, busy, a done pulse, the acknowledge error flag and the last
// read byte. One item is taken per clock cycle while the result output is not
// stalled; an item goes from the input register to the result register, and
// the sequencer state advances once per item between those two registers.
// Commands arriving while a transaction runs are ignored. Write the
// configuration registers only while the block is idle.
module i2c_register_transaction_master
  import i2crtm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] reg_addr, [15:8] write_data, [16] sda_in, [23:17] zero
  input  logic [23:0]         s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res, [4] ack_error,
  // [12:5] read_data, [15:13] zero
  output logic [15:0]         m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [6:0] dev_addr_q;
  logic [7:0] phase_q, start_stop_q, ack_timeout_q;
  logic       ack_after_q;

  logic       in_valid_q;
  logic [1:0] in_op_q;
  logic [7:0] in_raddr_q, in_wdata_q;
  logic       in_sda_q;

  logic       out_valid_q;
  result_t    out_q, out_d;

  logic [StepW-1:0] step_q, step_d;
  logic [BitW-1:0]  bit_q, bit_d;
  logic [7:0]       tmr_q, tmr_d;
  logic [7:0]       shift_q, shift_d;
  logic             isrd_q, isrd_d;
  logic [7:0]       raddr_q, raddr_d;
  logic [7:0]       wdata_q, wdata_d;
  logic [7:0]       rx_q, rx_d;
  logic             err_q, err_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;

  logic out_free, adv;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DEV_ADDR_RST;
      phase_q       <= PHASE_RST;
      start_stop_q  <= START_STOP_RST;
      ack_timeout_q <= ACK_TIMEOUT_RST;
      ack_after_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEV_ADDR:    dev_addr_q    <= cfg_data_i[6:0];
        CFG_PHASE:       phase_q       <= cfg_data_i;
        CFG_START_STOP:  start_stop_q  <= cfg_data_i;
        CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i;
        CFG_ACK_AFTER:   ack_after_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q    <= s_axis_tuser;
      in_raddr_q <= s_axis_tdata[7:0];
      in_wdata_q <= s_axis_tdata[15:8];
      in_sda_q   <= s_axis_tdata[16];
    end
  end

  always_comb begin
    logic [StageW-1:0] stage;
    logic              half;
    logic [7:0]        dur;
    logic [8:0]        tmr_up;
    logic              el;
    logic              go;
    logic [StageW-1:0] go_stg;
    logic [BitW-1:0]   go_part;
    logic              done;
    logic [StageW-1:0] nxt;

    stage   = step_q[StepW-1:1];
    half    = step_q[0];
    tmr_up  = {1'b0, tmr_q} + 9'd1;
    dur     = phase_q;
    el      = 1'b0;
    go      = 1'b0;
    go_stg  = STG_IDLE;
    go_part = PART_FIRST;
    done    = 1'b0;
    nxt     = STG_STOP;

    step_d  = step_q;
    bit_d   = bit_q;
    tmr_d   = tmr_q;
    shift_d = shift_q;
    isrd_d  = isrd_q;
    raddr_d = raddr_q;
    wdata_d = wdata_q;
    rx_d    = rx_q;
    err_d   = err_q;
    scl_d   = scl_q;
    sda_d   = sda_q;

    if (in_op_q == OP_WRITE || in_op_q == OP_READ) begin
      if (stage == STG_IDLE) begin
        raddr_d = in_raddr_q;
        wdata_d = in_wdata_q;
        isrd_d  = (in_op_q == OP_READ);
        err_d   = 1'b0;
        go      = 1'b1;
        go_stg  = STG_START;
        go_part = PART_SETUP;
      end
    end else begin
      case (stage)
        STG_START, STG_RSTART: begin
          if (bit_q == PART_FIRST) begin
            scl_d = 1'b0; sda_d = 1'b1; dur = phase_q;
          end else if (bit_q == PART_SETUP) begin
            scl_d = 1'b1; sda_d = 1'b1; dur = start_stop_q;
          end else begin
            scl_d = 1'b1; sda_d = 1'b0; dur = start_stop_q;
          end
          el    = tmr_up >= {1'b0, dur};
          tmr_d = el ? 8'd0 : tmr_up[7:0];
          if (el) begin
            if (bit_q < PART_LAST) begin
              bit_d = bit_q + 4'd1;
            end else begin
              go     = 1'b1;
              go_stg = (stage == STG_RSTART) ? STG_ADDRR : STG_ADDRW;
            end
          end
        end
        STG_ADDRW, STG_REG, STG_DATA, STG_ADDRR: begin
          scl_d = half;
          if (bit_q < BITS_BYTE) begin
            sda_d = shift_q[7];
            el    = tmr_up >= {1'b0, phase_q};
            tmr_d = el ? 8'd0 : tmr_up[7:0];
            if (el) begin
              if (!half) begin
                step_d[0] = 1'b1;
              end else begin
                step_d[0] = 1'b0;
                shift_d   = {shift_q[6:0], 1'b0};
                bit_d     = bit_q + 4'd1;
              end
            end
          end else begin
            sda_d = 1'b1;
            if (!half) begin
              el    = tmr_up >= {1'b0, phase_q};
              tmr_d = el ? 8'd0 : tmr_up[7:0];
              if (el) step_d[0] = 1'b1;
            end else if (!in_sda_q) begin
              if (stage == STG_ADDRW) nxt = STG_REG;
              else if (stage == STG_REG) nxt = isrd_q ? STG_RSTART : STG_DATA;
              else if (stage == STG_ADDRR) nxt = STG_READ;
              go     = 1'b1;
              go_stg = nxt;
            end else begin
              el    = tmr_up >= {1'b0, ack_timeout_q};
              tmr_d = el ? 8'd0 : tmr_up[7:0];
              if (el) begin
                err_d  = 1'b1;
                go     = 1'b1;
                go_stg = STG_STOP;
              end
            end
          end
        end
        STG_READ: begin
          sda_d = 1'b1;
          scl_d = half;
          if (half && tmr_q == 8'd0) shift_d = {shift_q[6:0], in_sda_q};
          el    = tmr_up >= {1'b0, phase_q};
          tmr_d = el ? 8'd0 : tmr_up[7:0];
          if (el) begin
            if (!half) begin
              step_d[0] = 1'b1;
            end else begin
              step_d[0] = 1'b0;
              bit_d     = bit_q + 4'd1;
              if (bit_d >= BITS_BYTE) begin
                rx_d   = shift_d;
                go     = 1'b1;
                go_stg = STG_MACK;
              end
            end
          end
        end
        STG_MACK: begin
          sda_d = !ack_after_q;
          scl_d = half;
          el    = tmr_up >= {1'b0, phase_q};
          tmr_d = el ? 8'd0 : tmr_up[7:0];
          if (el) begin
            if (!half) begin
              step_d[0] = 1'b1;
            end else begin
              go     = 1'b1;
              go_stg = STG_STOP;
            end
          end
        end
        STG_STOP: begin
          if (bit_q == PART_FIRST) begin
            scl_d = 1'b0; sda_d = 1'b0; dur = phase_q;
          end else if (bit_q == PART_SETUP) begin
            scl_d = 1'b1; sda_d = 1'b0; dur = start_stop_q;
          end else begin
            scl_d = 1'b1; sda_d = 1'b1; dur = start_stop_q;
          end
          el    = tmr_up >= {1'b0, dur};
          tmr_d = el ? 8'd0 : tmr_up[7:0];
          if (el) begin
            if (bit_q < PART_LAST) begin
              bit_d = bit_q + 4'd1;
            end else begin
              go     = 1'b1;
              go_stg = STG_IDLE;
              done   = 1'b1;
            end
          end
        end
        default: begin
          go    = 1'b1;
          scl_d = 1'b1;
          sda_d = 1'b1;
        end
      endcase
    end

    if (go) begin
      step_d = {go_stg, 1'b0};
      bit_d  = go_part;
      tmr_d  = 8'd0;
      case (go_stg)
        STG_ADDRW: shift_d = {dev_addr_q, 1'b0};
        STG_ADDRR: shift_d = {dev_addr_q, 1'b1};
        STG_REG:   shift_d = raddr_d;
        STG_DATA:  shift_d = wdata_d;
        STG_READ:  shift_d = 8'd0;
        default: ;
      endcase
    end

    out_d.scl_level = scl_d;
    out_d.sda_level = sda_d;
    out_d.busy_res  = (step_d[StepW-1:1] != STG_IDLE);
    out_d.done_res  = done;
    out_d.ack_error = err_d;
    out_d.read_data = rx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= {STG_IDLE, 1'b0};
      bit_q   <= '0;
      tmr_q   <= '0;
      shift_q <= '0;
      isrd_q  <= 1'b0;
      raddr_q <= '0;
      wdata_q <= '0;
      rx_q    <= '0;
      err_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (adv) begin
      step_q  <= step_d;
      bit_q   <= bit_d;
      tmr_q   <= tmr_d;
      shift_q <= shift_d;
      isrd_q  <= isrd_d;
      raddr_q <= raddr_d;
      wdata_q <= wdata_d;
      rx_q    <= rx_d;
      err_q   <= err_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

endmodule
